@@ src/rc_pwm_channel_decoder_assert.svh @@
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef RC_PWM_CHANNEL_DECODER_ASSERT_SVH
`define RC_PWM_CHANNEL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rcpwm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the RC PWM channel decoder.
// No dependencies; every source but the macro header imports it.
package rcpwm_pkg;

  localparam int ACT_W      = 2;
  localparam int CH_W       = 3;
  localparam int PULSE_W    = 16;
  localparam int NOISE_W    = 8;
  localparam int SIL_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = 24;
  localparam int Q_W        = 8;
  localparam int CMD_W      = 8;
  localparam int THR_W      = 7;

  localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RISE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FALL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2000;
  localparam logic [NOISE_W-1:0] NOISE_RST     = 8'd25;
  localparam logic [SIL_W-1:0]   TIMEOUT_RST   = 24'd1000000;
  localparam logic [SIL_W-1:0]   SIL_MAX       = 24'hFFFFFF;

  localparam logic [Q_W-1:0]   SCALE      = 8'd200;
  localparam logic [Q_W:0]     OFFSET     = 9'd100;

  localparam logic [CH_W-1:0] CH_PITCH    = 3'd0;
  localparam logic [CH_W-1:0] CH_ROLL     = 3'd1;
  localparam logic [CH_W-1:0] CH_YAW      = 3'd2;
  localparam logic [CH_W-1:0] CH_THROTTLE = 3'd3;

  typedef struct packed {
    logic ld_item;
    logic tick;
    logic rise;
    logic diff;
    logic cap;
    logic mul;
    logic div_step;
    logic commit;
    logic emit_fail;
    logic emit_frame;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             ch_ok;
    logic             ch_throttle;
    logic             fail_hit;
  } sts_t;

endpackage

@@ src/rcpwm_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for event input, frame output and configuration.
// Uses widths from rcpwm_pkg.
interface rcpwm_in_if;
  import rcpwm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       action;
  logic [CH_W-1:0]        channel;
  modport source (output valid, output action, output channel, input ready);
  modport sink (input valid, input action, input channel, output ready);
endinterface

interface rcpwm_out_if;
  import rcpwm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   healthy;
  logic signed [7:0]      pitch;
  logic signed [7:0]      roll;
  logic signed [7:0]      yaw;
  logic [THR_W-1:0]       throttle;
  modport source (output valid, output healthy, output pitch, output roll, output yaw,
                  output throttle, input ready);
  modport sink (input valid, input healthy, input pitch, input roll, input yaw,
                input throttle, output ready);
endinterface

interface rcpwm_cfg_if;
  import rcpwm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/rcpwm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing controller of the decoder: event decode, divider steps, result transfer.
// Depends on rcpwm_pkg and the assertion macro header.
`include "rc_pwm_channel_decoder_assert.svh"

module rcpwm_ctrl
  import rcpwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int ST_W  = 3;
  localparam int CNT_W = $clog2(Q_W);

  localparam logic [ST_W-1:0] S_IDLE       = 3'd0;
  localparam logic [ST_W-1:0] S_DECODE     = 3'd1;
  localparam logic [ST_W-1:0] S_CAP        = 3'd2;
  localparam logic [ST_W-1:0] S_MUL        = 3'd3;
  localparam logic [ST_W-1:0] S_DIV        = 3'd4;
  localparam logic [ST_W-1:0] S_COMMIT     = 3'd5;
  localparam logic [ST_W-1:0] S_EMIT_FAIL  = 3'd6;
  localparam logic [ST_W-1:0] S_EMIT_FRAME = 3'd7;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        unique case (sts.action)
          ACT_TICK: begin
            cmd.tick = 1'b1;
            if (sts.fail_hit) begin
              state_nxt = S_EMIT_FAIL;
            end
          end
          ACT_RISE: begin
            cmd.rise = sts.ch_ok;
          end
          ACT_FALL: begin
            if (sts.ch_ok) begin
              cmd.diff  = 1'b1;
              state_nxt = S_CAP;
            end
          end
          ACT_NONE: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.ch_throttle ? S_EMIT_FRAME : S_IDLE;
      end
      S_EMIT_FAIL: begin
        if (slot_free) begin
          cmd.emit_fail = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMIT_FRAME: begin
        if (slot_free) begin
          cmd.emit_frame = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit_fail || cmd.emit_frame) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RCPWM_ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, state_r == S_DECODE, "accepted event not decoded")
  `RCPWM_ASSERT_NEXT(a_div_ends, state_r == S_DIV && cnt_r == '0, state_r == S_COMMIT, "divider did not finish after its last step")
  `RCPWM_ASSERT_NEXT(a_emit_waits, (state_r == S_EMIT_FAIL || state_r == S_EMIT_FRAME) && out_valid_r && !out_ready, state_r == $past(state_r) && out_valid_r, "result overwritten while output is stalled")

endmodule

@@ src/rcpwm_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the decoder: timer, start stamps, width scaling, divider and result register.
// Depends on rcpwm_pkg and the assertion macro header.
`include "rc_pwm_channel_decoder_assert.svh"

module rcpwm_dp
  import rcpwm_pkg::*;
#(
  parameter int CHANNEL_COUNT = 6,
  parameter int TIMER_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [CH_W-1:0]        in_channel,
  output logic                   out_healthy,
  output logic signed [7:0]      out_pitch,
  output logic signed [7:0]      out_roll,
  output logic signed [7:0]      out_yaw,
  output logic [THR_W-1:0]       out_throttle,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int CH_IDX_W = $clog2(CHANNEL_COUNT);

  logic [PULSE_W-1:0]        max_r;
  logic [NOISE_W-1:0]        noise_r;
  logic [SIL_W-1:0]          timeout_r;

  logic [ACT_W-1:0]          act_r;
  logic [CH_W-1:0]           ch_r;
  logic [TIMER_BITS-1:0]     timer_r;
  logic [TIMER_BITS-1:0]     stamp_r [CHANNEL_COUNT];
  logic [SIL_W-1:0]          silence_r;
  logic                      failrep_r;
  logic signed [7:0]         pitch_r, roll_r, yaw_r;

  logic [TIMER_BITS-1:0]     diff_r;
  logic [PULSE_W-1:0]        w_r;
  logic [PROD_W-1:0]         rem_r;
  logic [PROD_W-1:0]         div_r;
  logic [Q_W-1:0]            q_r;

  logic [CH_IDX_W-1:0]       ch_idx;
  logic [SIL_W-1:0]          sil_inc;
  logic [PULSE_W-1:0]        capped;
  logic [PULSE_W-1:0]        w_nxt;
  logic                      div_ge;
  logic [Q_W:0]              n_full;
  logic signed [7:0]         n_val;

  assign ch_idx  = ch_r[CH_IDX_W-1:0];
  assign sil_inc = (silence_r == SIL_MAX) ? silence_r : silence_r + 1'b1;
  assign capped  = (diff_r > TIMER_BITS'(max_r)) ? max_r : diff_r[PULSE_W-1:0];
  assign w_nxt   = (capped < PULSE_W'(noise_r)) ? '0 : capped;
  assign div_ge  = (rem_r >= div_r) && (max_r != '0);
  assign n_full  = {1'b0, q_r} - OFFSET;
  assign n_val   = n_full[7:0];

  assign sts.action      = act_r;
  assign sts.ch_ok       = ({1'b0, ch_r} < 4'(CHANNEL_COUNT));
  assign sts.ch_throttle = (ch_r == CH_THROTTLE);
  assign sts.fail_hit    = !failrep_r && (sil_inc >= timeout_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= MAX_PULSE_RST;
      noise_r   <= NOISE_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_PULSE: max_r     <= cfg_data[PULSE_W-1:0];
        CFG_NOISE:     noise_r   <= cfg_data[NOISE_W-1:0];
        CFG_TIMEOUT:   timeout_r <= cfg_data[SIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r   <= '0;
      silence_r <= '0;
      failrep_r <= 1'b0;
      pitch_r   <= '0;
      roll_r    <= '0;
      yaw_r     <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        stamp_r[i] <= '0;
      end
    end else begin
      if (cmd.tick) begin
        timer_r   <= timer_r + 1'b1;
        silence_r <= sil_inc;
        if (sts.fail_hit) begin
          failrep_r <= 1'b1;
        end
      end
      if (cmd.rise) begin
        if (ch_r == CH_PITCH) begin
          timer_r         <= '0;
          stamp_r[ch_idx] <= '0;
        end else begin
          stamp_r[ch_idx] <= timer_r;
        end
      end
      if (cmd.diff) begin
        silence_r <= '0;
        failrep_r <= 1'b0;
      end
      if (cmd.commit) begin
        unique case (ch_r)
          CH_PITCH: pitch_r <= n_val;
          CH_ROLL:  roll_r  <= n_val;
          CH_YAW:   yaw_r   <= n_val;
          default: begin
          end
        endcase
      end
      if (cmd.emit_frame) begin
        pitch_r <= '0;
        roll_r  <= '0;
        yaw_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      act_r <= in_action;
      ch_r  <= in_channel;
    end
    if (cmd.diff) begin
      diff_r <= timer_r - stamp_r[ch_idx];
    end
    if (cmd.cap) begin
      w_r <= w_nxt;
    end
    if (cmd.mul) begin
      rem_r <= PROD_W'(w_r) * PROD_W'(SCALE);
      div_r <= PROD_W'({max_r, {(Q_W - 1){1'b0}}});
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - div_r;
      end
      div_r <= div_r >> 1;
      q_r   <= {q_r[Q_W-2:0], div_ge};
    end
    if (cmd.emit_fail) begin
      out_healthy  <= 1'b0;
      out_pitch    <= '0;
      out_roll     <= '0;
      out_yaw      <= '0;
      out_throttle <= '0;
    end
    if (cmd.emit_frame) begin
      out_healthy  <= 1'b1;
      out_pitch    <= pitch_r;
      out_roll     <= roll_r;
      out_yaw      <= yaw_r;
      out_throttle <= q_r[Q_W-1:1];
    end
  end

  `RCPWM_ASSERT_NOW(a_quot_range, cmd.commit, q_r <= SCALE, "normalized quotient above full scale")
  `RCPWM_ASSERT_NEXT(a_fall_clears, cmd.diff, silence_r == '0 && !failrep_r, "falling edge did not restart silence count")
  `RCPWM_ASSERT_NEXT(a_frame_clears, cmd.emit_frame, pitch_r == '0 && roll_r == '0 && yaw_r == '0, "held axes not cleared after frame")

endmodule

@@ src/rc_pwm_channel_decoder.sv @@
`timescale 1ns / 1ps
// RC receiver pulse-width decoder: top level joining controller and datapath.
// Depends on rcpwm_pkg, the channel interfaces, rcpwm_ctrl and rcpwm_dp.
//
// Usage: in_ch carries one event per transfer: a one-microsecond tick, a rising
// edge or a falling edge with its receiver channel. out_ch carries command
// frames, sent after a throttle falling edge, and silence failure reports.
// cfg_ch writes max_pulse_us (index 0), noise_floor_us (1) and
// silence_timeout_us (2); it is always ready. The user must see that it is
// written only while idle; the block does not enforce this. Events are handled
// one at a time. A tick or a rising edge passes through decode, plus an emit
// state for a failure result; a falling edge through decode, cap, multiply, the
// 8-step restoring divider, commit and, for a frame, emit. out_ch is registered.
// Reset clears the timer, start stamps, held axes and silence state and loads
// the register defaults. While the receiver stalls, the result stays in the
// output register and the next event is still accepted; only a second result
// waits until the first one has been transferred.
module rc_pwm_channel_decoder
  import rcpwm_pkg::*;
#(
  parameter int CHANNEL_COUNT = 6,
  parameter int TIMER_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  rcpwm_in_if.sink         in_ch,
  rcpwm_out_if.source      out_ch,
  rcpwm_cfg_if.sink        cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rcpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcpwm_dp #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .TIMER_BITS    (TIMER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .in_action    (in_ch.action),
    .in_channel   (in_ch.channel),
    .out_healthy  (out_ch.healthy),
    .out_pitch    (out_ch.pitch),
    .out_roll     (out_ch.roll),
    .out_yaw      (out_ch.yaw),
    .out_throttle (out_ch.throttle),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

@@ bench/tb_rc_pwm_channel_decoder.sv @@
`timescale 1ns / 1ps
// Testbench for rc_pwm_channel_decoder: a table of directed events, then random receiver frames.
// Each result is checked against the table's expected frame or a behavioral model kept here.
// Depends on rcpwm_pkg, the channel interfaces in rcpwm_if.sv and the decoder RTL.
module tb_rc_pwm_channel_decoder;
  import rcpwm_pkg::*;

  localparam int CHANNELS      = 6;
  localparam int EVENT_GOAL    = 1250;
  localparam int FRAME_GOAL    = 40;
  localparam int CALM_EVENTS   = 150;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CH_W-1:0] CH_AUX_A = 3'd4;
  localparam logic [CH_W-1:0] CH_AUX_B = 3'd5;
  localparam logic [CH_W-1:0] CH_LAST  = 3'd7;
  localparam logic [CH_W-1:0] SIDE_CH [5] = '{CH_PITCH, CH_ROLL, CH_YAW, CH_AUX_A, CH_AUX_B};

  localparam logic signed [7:0] CMD_LOW  = -8'sd100;
  localparam logic signed [7:0] CMD_HIGH = 8'sd100;
  localparam logic signed [7:0] CMD_MID  = 8'sd0;
  localparam logic [THR_W-1:0]  THR_FULL = 7'd100;
  localparam logic [THR_W-1:0]  THR_OFF  = 7'd0;

  typedef struct packed {
    logic              healthy;
    logic signed [7:0] pitch;
    logic signed [7:0] roll;
    logic signed [7:0] yaw;
    logic [THR_W-1:0]  throttle;
  } frame_t;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [ACT_W-1:0]   action;
    logic [CH_W-1:0]    channel;
    logic [PULSE_W-1:0] full_scale;
    logic [NOISE_W-1:0] floor;
    logic [SIL_W-1:0]   limit;
    bit                 typed;
    frame_t             want;
  } plan_row_t;

  localparam frame_t SILENCE_REPORT = '0;
  localparam frame_t IDLE_FRAME = {1'b1, CMD_MID, CMD_MID, CMD_MID, THR_OFF};

  localparam int PLAN_ROWS = 29;
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_EVENT,  ACT_FALL, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b1, IDLE_FRAME},
    '{ROW_EVENT,  ACT_NONE, CH_LAST,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_LAST,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_AUX_B,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_CONFIG, ACT_TICK, CH_PITCH,    16'd0, 8'd255, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b1, SILENCE_REPORT},
    '{ROW_EVENT,  ACT_RISE, CH_ROLL,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_ROLL,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b1,
      {1'b1, CMD_MID, CMD_LOW, CMD_MID, THR_OFF}},
    '{ROW_EVENT,  ACT_TICK, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b1, SILENCE_REPORT},
    '{ROW_CONFIG, ACT_TICK, CH_PITCH,    16'hFFFF, 8'd0, SIL_MAX, 1'b0, '0},
    '{ROW_EVENT,  ACT_RISE, CH_ROLL,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_RISE, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_ROLL,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_RISE, CH_YAW,      16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_YAW,      16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b1,
      {1'b1, CMD_LOW, CMD_HIGH, CMD_LOW, THR_OFF}},
    '{ROW_CONFIG, ACT_TICK, CH_PITCH,    16'd1, 8'd5, 24'd2, 1'b0, '0},
    '{ROW_EVENT,  ACT_RISE, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b1, IDLE_FRAME},
    '{ROW_CONFIG, ACT_TICK, CH_PITCH,    16'd1, 8'd0, 24'd2, 1'b0, '0},
    '{ROW_EVENT,  ACT_RISE, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_PITCH,    16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_FALL, CH_THROTTLE, 16'd0, 8'd0, 24'd0, 1'b1,
      {1'b1, CMD_MID, CMD_MID, CMD_MID, THR_FULL}},
    '{ROW_EVENT,  ACT_TICK, CH_ROLL,     16'd0, 8'd0, 24'd0, 1'b0, '0},
    '{ROW_EVENT,  ACT_TICK, CH_YAW,      16'd0, 8'd0, 24'd0, 1'b1, SILENCE_REPORT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  bit   calm = 1'b0;
  int   stall_left = 0;
  int   events_sent = 0;
  int   frames_seen = 0;
  int   mismatches = 0;
  frame_t frames_due[$];

  logic [PULSE_W-1:0] full_scale = MAX_PULSE_RST;
  logic [NOISE_W-1:0] noise_floor = NOISE_RST;
  logic [SIL_W-1:0]   quiet_limit = TIMEOUT_RST;
  logic [31:0]        clock_us = '0;
  logic [31:0]        rise_stamp [CHANNELS] = '{default: '0};
  logic signed [7:0]  pitch_cmd = '0;
  logic signed [7:0]  roll_cmd = '0;
  logic signed [7:0]  yaw_cmd = '0;
  logic [SIL_W-1:0]   quiet_ticks = '0;
  logic               silence_flagged = 1'b0;

  rcpwm_in_if  in_ch ();
  rcpwm_out_if out_ch ();
  rcpwm_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  rc_pwm_channel_decoder #(
    .CHANNEL_COUNT(CHANNELS),
    .TIMER_BITS   (32)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [7:0] scale_width(input logic [31:0] width);
    logic [31:0] w;
    logic [31:0] q;
    w = width;
    if (w > full_scale) w = full_scale;
    if (w < noise_floor) w = '0;
    q = (full_scale == '0) ? '0 : (32'd200 * w) / full_scale;
    return 8'(int'(q) - 100);
  endfunction

  function automatic bit decode_event(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                                      output frame_t res);
    logic signed [7:0] cmd;
    res = '0;
    if (act == ACT_TICK) begin
      clock_us = clock_us + 32'd1;
      if (quiet_ticks != SIL_MAX) quiet_ticks = quiet_ticks + 1'b1;
      if (!silence_flagged && quiet_ticks >= quiet_limit) begin
        silence_flagged = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (act == ACT_NONE || ch >= CHANNELS) return 1'b0;
    if (act == ACT_RISE) begin
      if (ch == CH_PITCH) clock_us = '0;
      rise_stamp[ch] = clock_us;
      return 1'b0;
    end
    quiet_ticks = '0;
    silence_flagged = 1'b0;
    cmd = scale_width(clock_us - rise_stamp[ch]);
    case (ch)
      CH_PITCH: pitch_cmd = cmd;
      CH_ROLL: roll_cmd = cmd;
      CH_YAW: yaw_cmd = cmd;
      CH_THROTTLE: begin
        res = {1'b1, pitch_cmd, roll_cmd, yaw_cmd, THR_W'((int'(cmd) + 100) / 2)};
        pitch_cmd = '0;
        roll_cmd = '0;
        yaw_cmd = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_event(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                            input bit typed = 1'b0, input frame_t want = '0);
    frame_t predicted;
    bit made;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.channel <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    made = decode_event(act, ch, predicted);
    if (typed) frames_due.push_back(want);
    else if (made) frames_due.push_back(predicted);
    events_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_pulse(input logic [CH_W-1:0] ch, input int span);
    send_event(ACT_RISE, ch);
    repeat ($urandom_range(0, span)) send_event(ACT_TICK, CH_W'($urandom_range(0, 7)));
    send_event(ACT_FALL, ch);
  endtask

  task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_MAX_PULSE: full_scale = val[PULSE_W-1:0];
      CFG_NOISE: noise_floor = val[NOISE_W-1:0];
      CFG_TIMEOUT: quiet_limit = val[SIL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [PULSE_W-1:0] scale, input logic [NOISE_W-1:0] floor,
                              input logic [SIL_W-1:0] limit);
    cfg_transfer(CFG_MAX_PULSE, CFG_DATA_W'(scale));
    cfg_transfer(CFG_NOISE, CFG_DATA_W'(floor));
    cfg_transfer(CFG_TIMEOUT, CFG_DATA_W'(limit));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_frames();
    int waited;
    in_ch.valid <= 1'b0;
    for (waited = 0; frames_due.size() != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t seen;
    frame_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.healthy, out_ch.pitch, out_ch.roll, out_ch.yaw, out_ch.throttle};
      frames_seen++;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result transfer: healthy %0d pitch %0d roll %0d yaw %0d thr %0d",
                   seen.healthy, seen.pitch, seen.roll, seen.yaw, seen.throttle);
      end else begin
        due = frames_due.pop_front();
        if (seen.healthy !== due.healthy || seen.pitch !== due.pitch ||
            seen.roll !== due.roll || seen.yaw !== due.yaw || seen.throttle !== due.throttle) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"result %0d mismatch: expected h %0d p %0d r %0d y %0d t %0d,",
                      " got h %0d p %0d r %0d y %0d t %0d"}, frames_seen,
                     due.healthy, due.pitch, due.roll, due.yaw, due.throttle,
                     seen.healthy, seen.pitch, seen.roll, seen.yaw, seen.throttle);
        end
      end
    end
  end

  initial begin
    logic [PULSE_W-1:0] scale;
    logic [NOISE_W-1:0] floor;
    logic [SIL_W-1:0]   limit;
    int span;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.channel = CH_PITCH;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_PULSE;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CONFIG) begin
        drain_frames();
        write_config(plan[r].full_scale, plan[r].floor, plan[r].limit);
      end else begin
        send_event(plan[r].action, plan[r].channel, plan[r].typed, plan[r].want);
      end
    end

    while (events_sent < EVENT_GOAL || frames_seen < FRAME_GOAL) begin
      if (events_sent >= EVENT_GOAL - CALM_EVENTS) calm <= 1'b1;
      drain_frames();
      case ($urandom_range(0, 7))
        0: scale = 16'hFFFF;
        1: scale = 16'd1;
        default: scale = PULSE_W'($urandom_range(4, 40));
      endcase
      if ($urandom_range(0, 5) == 0) floor = NOISE_W'($urandom_range(0, 255));
      else floor = NOISE_W'($urandom_range(0, (scale > 80) ? 40 : scale / 2));
      if ($urandom_range(0, 7) == 0) limit = SIL_MAX;
      else limit = SIL_W'($urandom_range(1, 60));
      write_config(scale, floor, limit);
      span = (full_scale > 40) ? 40 : full_scale + 4;

      repeat ($urandom_range(2, 5)) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          repeat ($urandom_range(3, 10))
            send_event(ACT_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 7)));
        end else if (pick == 1 && quiet_limit <= 100) begin
          repeat (quiet_limit + $urandom_range(0, 3))
            send_event(ACT_TICK, CH_W'($urandom_range(0, 7)));
        end else begin
          repeat ($urandom_range(0, 5)) send_pulse(SIDE_CH[$urandom_range(0, 4)], span);
          send_pulse(CH_THROTTLE, span);
        end
      end
    end

    drain_frames();
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ rc_pwm_channel_decoder.f @@
+incdir+src
src/rcpwm_pkg.sv
src/rcpwm_if.sv
src/rcpwm_ctrl.sv
src/rcpwm_dp.sv
src/rc_pwm_channel_decoder.sv
bench/tb_rc_pwm_channel_decoder.sv
